// ===== rtl/nfcr_pkg.sv =====
// nfcr_pkg: types and constants shared by the reader uart frame receiver
// no dependencies

package nfcr_pkg;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_PAYLOAD,
		PH_DCS,
		PH_POST,
		PH_ACKPOST
	} phase_t;

	// result kinds, carried on m_tuser
	localparam logic [2:0] KIND_DATA     = 3'd0;
	localparam logic [2:0] KIND_DONE     = 3'd1;
	localparam logic [2:0] KIND_ACK      = 3'd2;
	localparam logic [2:0] KIND_BADSTART = 3'd3;
	localparam logic [2:0] KIND_BADLCS   = 3'd4;
	localparam logic [2:0] KIND_TOOLONG  = 3'd5;
	localparam logic [2:0] KIND_TIMEOUT  = 3'd6;
	localparam logic [2:0] KIND_NOTACK   = 3'd7;

	// input operations, carried on s_tuser
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// configuration register indexes
	localparam logic REG_MAX_PAYLOAD   = 1'b0;
	localparam logic REG_TIMEOUT_TICKS = 1'b1;

	localparam logic [15:0] MAX_PAYLOAD_RESET   = 16'd282;
	localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;

	localparam logic [7:0] LCS_ACK_BYTE = 8'hff;
	localparam logic [7:0] ACK_POST_BYTE = 8'h00;
	localparam logic [2:0] HDR_LAST = 3'd5;

	// expected preamble and start code bytes 00 00 ff
	function automatic logic [7:0] start_byte(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0:    r = 8'h00;
			2'd1:    r = 8'h00;
			2'd2:    r = 8'hff;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/nfc_uart_frame_receiver.sv =====
// nfc_uart_frame_receiver: byte-wise deframer for reader uart responses
// depends on nfcr_pkg

// Takes one request per clock: either a received uart byte (s_tuser 0) or a
// timer tick (s_tuser 1). Each request passes through an input register, one
// level of deframing logic and an output register. One request per cycle is
// sustained. s_tready
// drops only when the input register holds a request and the output register
// holds a result that m_tready does not take in that cycle. Payload bytes come
// out as kind 0; the end of a frame gives kind 1 with the length and the data
// checksum verdict; ack, not-ack, bad start, bad length checksum, too long and
// timeout have kinds of their own. Write max_payload and timeout_ticks only
// while no request is in flight.

module nfc_uart_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	input  logic        s_tuser,  // [0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [7:0] data_byte, [23:8] frame_length, [24] dcs_ok
	output logic [2:0]  m_tuser   // [2:0] kind
);
	import nfcr_pkg::*;

	logic [15:0] max_payload_q;
	logic [15:0] timeout_ticks_q;

	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  byte_s1;

	phase_t      phase_q, phase_d;
	logic [2:0]  hdr_cnt_q, hdr_cnt_d;
	logic        start_ok_q, start_ok_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [15:0] pay_len_q, pay_len_d;
	logic [15:0] left_q, left_d;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] ticks_q, ticks_d;

	logic        emit;
	logic [2:0]  kind_d;
	logic [7:0]  data_d;
	logic [15:0] flen_d;
	logic        ok_d;

	logic        res_valid_q;
	logic [2:0]  kind_q;
	logic [7:0]  data_q;
	logic [15:0] flen_q;
	logic        ok_q;

	logic        go_s1;
	logic        in_frame;
	logic [15:0] ticks_inc;
	logic [7:0]  lcs_sum;

	assign go_s1    = valid_s1 && (!res_valid_q || m_tready);
	assign s_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q   <= MAX_PAYLOAD_RESET;
			timeout_ticks_q <= TIMEOUT_TICKS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_PAYLOAD:   max_payload_q   <= cfg_data;
				REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	assign in_frame  = (phase_q != PH_HUNT) || (hdr_cnt_q != 3'd0);
	assign ticks_inc = (ticks_q != 16'hffff) ? ticks_q + 16'd1 : ticks_q;
	assign lcs_sum   = len_hi_q + pay_len_q[7:0] + byte_s1;

	always_comb begin
		phase_d    = phase_q;
		hdr_cnt_d  = hdr_cnt_q;
		start_ok_d = start_ok_q;
		len_hi_d   = len_hi_q;
		pay_len_d  = pay_len_q;
		left_d     = left_q;
		sum_d      = sum_q;
		ticks_d    = ticks_q;
		emit       = 1'b0;
		kind_d     = KIND_DATA;
		data_d     = 8'h00;
		flen_d     = 16'h0000;
		ok_d       = 1'b0;

		if (op_s1 == OP_TICK) begin
			if (in_frame) begin
				ticks_d = ticks_inc;
				if (ticks_inc >= timeout_ticks_q) begin
					emit       = 1'b1;
					kind_d     = KIND_TIMEOUT;
					phase_d    = PH_HUNT;
					hdr_cnt_d  = 3'd0;
					start_ok_d = 1'b1;
					ticks_d    = 16'h0000;
				end
			end
		end else begin
			unique case (phase_q)
				PH_PAYLOAD: begin
					sum_d  = sum_q + byte_s1;
					left_d = left_q - 16'd1;
					if (left_q == 16'd1) begin
						phase_d = PH_DCS;
					end
					emit   = 1'b1;
					kind_d = KIND_DATA;
					data_d = byte_s1;
				end
				PH_DCS: begin
					sum_d   = sum_q + byte_s1;
					phase_d = PH_POST;
				end
				PH_POST: begin
					// postamble value is not checked
					emit       = 1'b1;
					kind_d     = KIND_DONE;
					flen_d     = pay_len_q;
					ok_d       = (sum_q == 8'h00);
					phase_d    = PH_HUNT;
					hdr_cnt_d  = 3'd0;
					start_ok_d = 1'b1;
					ticks_d    = 16'h0000;
				end
				PH_ACKPOST: begin
					emit       = 1'b1;
					kind_d     = (byte_s1 == ACK_POST_BYTE) ? KIND_ACK : KIND_NOTACK;
					phase_d    = PH_HUNT;
					hdr_cnt_d  = 3'd0;
					start_ok_d = 1'b1;
					ticks_d    = 16'h0000;
				end
				PH_HUNT: begin
					if (hdr_cnt_q == 3'd0) begin
						ticks_d = 16'h0000;
					end
					if (hdr_cnt_q < 3'd3) begin
						if (byte_s1 != start_byte(hdr_cnt_q[1:0])) begin
							start_ok_d = 1'b0;
						end
						hdr_cnt_d = hdr_cnt_q + 3'd1;
					end else if (hdr_cnt_q == 3'd3) begin
						len_hi_d  = byte_s1;
						hdr_cnt_d = 3'd4;
					end else if (hdr_cnt_q == 3'd4) begin
						pay_len_d = {len_hi_q, byte_s1};
						hdr_cnt_d = HDR_LAST;
					end else begin
						// length checksum byte: start code, ack, checksum, limit
						hdr_cnt_d  = 3'd0;
						start_ok_d = 1'b1;
						if (!start_ok_q) begin
							emit    = 1'b1;
							kind_d  = KIND_BADSTART;
							ticks_d = 16'h0000;
						end else if (pay_len_q == 16'h0000 && byte_s1 == LCS_ACK_BYTE) begin
							phase_d = PH_ACKPOST;
						end else if (lcs_sum != 8'h00) begin
							emit    = 1'b1;
							kind_d  = KIND_BADLCS;
							ticks_d = 16'h0000;
						end else if (pay_len_q > max_payload_q) begin
							emit    = 1'b1;
							kind_d  = KIND_TOOLONG;
							ticks_d = 16'h0000;
						end else begin
							left_d  = pay_len_q;
							sum_d   = 8'h00;
							phase_d = (pay_len_q != 16'h0000) ? PH_PAYLOAD : PH_DCS;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			hdr_cnt_q   <= 3'd0;
			start_ok_q  <= 1'b1;
			len_hi_q    <= 8'h00;
			pay_len_q   <= 16'h0000;
			left_q      <= 16'h0000;
			sum_q       <= 8'h00;
			ticks_q     <= 16'h0000;
			res_valid_q <= 1'b0;
		end else begin
			if (go_s1) begin
				phase_q     <= phase_d;
				hdr_cnt_q   <= hdr_cnt_d;
				start_ok_q  <= start_ok_d;
				len_hi_q    <= len_hi_d;
				pay_len_q   <= pay_len_d;
				left_q      <= left_d;
				sum_q       <= sum_d;
				ticks_q     <= ticks_d;
				res_valid_q <= emit;
			end else if (m_tready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && emit) begin
			kind_q <= kind_d;
			data_q <= data_d;
			flen_q <= flen_d;
			ok_q   <= ok_d;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {7'd0, ok_q, flen_q, data_q};

	// header counting happens only while hunting
	a_hdr_only_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_HUNT) |-> (hdr_cnt_q == 3'd0))
		else $error("header count nonzero outside hunt");

	// payload phase always has bytes left
	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (left_q != 16'h0000))
		else $error("payload phase with no bytes left");

	// no tick count outside a frame
	a_ticks_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HUNT && hdr_cnt_q == 3'd0) |-> (ticks_q == 16'h0000))
		else $error("tick count held while not in a frame");

	// only payload results carry a data byte
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != KIND_DATA) |-> (m_tdata[7:0] == 8'h00))
		else $error("data byte on a non-payload result");

	// a result waiting on the output blocks a full input register
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_tvalid && !m_tready) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input register lost a request during stall");

endmodule

// ===== tb/testbench.sv =====
// testbench for nfc_uart_frame_receiver: drives uart bytes and timer ticks, predicts
// every deframer result in a scoreboard class and checks the output stream
// depends on nfcr_pkg and rtl/nfc_uart_frame_receiver.sv

module testbench;
	import nfcr_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS  = 325;
	localparam int NUM_PHASES   = 6;
	localparam int REPORT_LIMIT = 10;
	localparam logic [23:0] START_CODE = 24'h0000ff;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  data_byte;
		logic [15:0] frame_length;
		logic        dcs_ok;
	} deframe_result_t;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} uart_req_t;

	class frame_scoreboard;
		logic [15:0] max_len;
		logic [15:0] tick_limit;
		phase_t      ph;
		logic [2:0]  hdr_cnt;
		bit          start_good;
		logic [7:0]  len_hi;
		logic [15:0] pay_len;
		logic [15:0] remaining;
		logic [7:0]  sum;
		logic [15:0] ticks;
		deframe_result_t expected[$];
		int mismatches;
		int requests;
		int results;
		int kind_hits[8];

		function new();
			max_len = MAX_PAYLOAD_RESET;
			tick_limit = TIMEOUT_TICKS_RESET;
			return_to_hunt();
			len_hi = '0;
			pay_len = '0;
			remaining = '0;
			sum = '0;
			mismatches = 0;
			requests = 0;
			results = 0;
			foreach (kind_hits[i])
				kind_hits[i] = 0;
		endfunction

		function void return_to_hunt();
			ph = PH_HUNT;
			hdr_cnt = '0;
			start_good = 1'b1;
			ticks = '0;
		endfunction

		function void write_reg(logic idx, logic [15:0] value);
			if (idx == REG_MAX_PAYLOAD)
				max_len = value;
			else
				tick_limit = value;
		endfunction

		function void note_request(logic op, logic [7:0] b);
			deframe_result_t r;
			bit produces;
			bit in_frame;
			logic [7:0] lcs_sum;
			r = '0;
			produces = 1'b0;
			requests++;
			in_frame = (ph != PH_HUNT) || (hdr_cnt != 0);
			if (op == OP_TICK) begin
				// ticks only count once a header byte has arrived
				if (in_frame) begin
					if (ticks != 16'hffff)
						ticks++;
					if (ticks >= tick_limit) begin
						return_to_hunt();
						r.kind = KIND_TIMEOUT;
						produces = 1'b1;
					end
				end
			end else begin
				case (ph)
					PH_PAYLOAD: begin
						sum += b;
						remaining--;
						if (remaining == 0)
							ph = PH_DCS;
						r.kind = KIND_DATA;
						r.data_byte = b;
						produces = 1'b1;
					end
					PH_DCS: begin
						sum += b;
						ph = PH_POST;
					end
					PH_POST: begin
						r.kind = KIND_DONE;
						r.frame_length = pay_len;
						r.dcs_ok = (sum == 0);
						return_to_hunt();
						produces = 1'b1;
					end
					PH_ACKPOST: begin
						r.kind = (b == ACK_POST_BYTE) ? KIND_ACK : KIND_NOTACK;
						return_to_hunt();
						produces = 1'b1;
					end
					default: begin
						if (hdr_cnt == 0)
							ticks = '0;
						lcs_sum = len_hi + pay_len[7:0] + b;
						if (hdr_cnt < 3) begin
							if (b != START_CODE[23 - 8 * hdr_cnt -: 8])
								start_good = 1'b0;
							hdr_cnt++;
						end else if (hdr_cnt == 3) begin
							len_hi = b;
							hdr_cnt = 3'd4;
						end else if (hdr_cnt == 4) begin
							pay_len = {len_hi, b};
							hdr_cnt = HDR_LAST;
						end else if (!start_good) begin
							return_to_hunt();
							r.kind = KIND_BADSTART;
							produces = 1'b1;
						end else if (pay_len == 0 && b == LCS_ACK_BYTE) begin
							ph = PH_ACKPOST;
							hdr_cnt = '0;
						end else if (lcs_sum != 0) begin
							return_to_hunt();
							r.kind = KIND_BADLCS;
							produces = 1'b1;
						end else if (pay_len > max_len) begin
							return_to_hunt();
							r.kind = KIND_TOOLONG;
							produces = 1'b1;
						end else begin
							remaining = pay_len;
							sum = '0;
							hdr_cnt = '0;
							ph = (pay_len != 0) ? PH_PAYLOAD : PH_DCS;
						end
					end
				endcase
			end
			if (produces)
				expected.push_back(r);
		endfunction

		function void check_result(logic [2:0] kind, logic [31:0] word);
			deframe_result_t want;
			logic [31:0] want_word;
			results++;
			if (expected.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("error: unexpected result kind %0d tdata %h", kind, word);
				return;
			end
			want = expected.pop_front();
			want_word = {7'b0, want.dcs_ok, want.frame_length, want.data_byte};
			kind_hits[want.kind]++;
			if (kind !== want.kind || word !== want_word) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$write("error: result %0d expected kind %0d byte %h len %h ok %b,",
						results, want.kind, want.data_byte, want.frame_length,
						want.dcs_ok);
					$display(" got kind %0d byte %h len %h ok %b pad %h",
						kind, word[7:0], word[23:8], word[24], word[31:25]);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_MAX_PAYLOAD;
	logic [15:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = OP_BYTE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;

	frame_scoreboard sb = new();
	uart_req_t stim_q[$];
	int tx_idle_pct = 37;
	int rx_idle_pct = 50;
	int tick_pct = 0;
	int phase_items = 0;

	nfc_uart_frame_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// values seen here are the ones from before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata);
			if (s_tvalid && s_tready)
				sb.note_request(s_tuser, s_tdata);
		end
	end

	function void push_byte(logic [7:0] b);
		int n;
		if ($urandom_range(0, 99) < tick_pct) begin
			n = $urandom_range(1, 4);
			repeat (n) begin
				stim_q.push_back({OP_TICK, 8'($urandom)});
				phase_items++;
			end
		end
		stim_q.push_back({OP_BYTE, b});
		phase_items++;
	endfunction

	function void push_header(logic [23:0] start, logic [15:0] len, logic [7:0] lcs);
		push_byte(start[23:16]);
		push_byte(start[15:8]);
		push_byte(start[7:0]);
		push_byte(len[15:8]);
		push_byte(len[7:0]);
		push_byte(lcs);
	endfunction

	function logic [7:0] len_checksum(logic [15:0] len);
		return 8'(0 - len[15:8] - len[7:0]);
	endfunction

	function void build_burst();
		int pick;
		int n;
		logic [15:0] len;
		logic [7:0] b;
		logic [7:0] dsum;
		logic [15:0] lim;
		pick = $urandom_range(0, 99);
		lim = sb.max_len;
		if (pick < 42) begin
			// good header, mostly short, now and then at the length limit, dcs sometimes wrong
			if ($urandom_range(0, 24) == 0 && lim <= 300)
				len = lim;
			else
				len = 16'($urandom_range(0, (lim < 8) ? lim : 8));
			push_header(START_CODE, len, len_checksum(len));
			dsum = '0;
			for (int i = 0; i < len; i++) begin
				b = 8'($urandom);
				dsum += b;
				push_byte(b);
			end
			push_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(0 - dsum));
			push_byte(8'($urandom));
		end else if (pick < 54) begin
			push_header(START_CODE, 16'h0000, LCS_ACK_BYTE);
			push_byte($urandom_range(0, 1) ? ACK_POST_BYTE : 8'($urandom_range(1, 255)));
		end else if (pick < 64) begin
			len = 16'($urandom);
			push_header(START_CODE ^ 24'($urandom_range(1, 24'hffffff)), len,
				len_checksum(len));
		end else if (pick < 74) begin
			len = 16'($urandom);
			push_header(START_CODE, len, len_checksum(len) + 8'($urandom_range(1, 255)));
		end else if (pick < 84) begin
			if (lim != 16'hffff) begin
				len = $urandom_range(0, 1) ? lim + 16'd1
					: 16'($urandom_range(lim + 1, 65535));
				push_header(START_CODE, len, len_checksum(len));
			end else begin
				// no length can exceed the limit, send an empty frame instead
				push_header(START_CODE, 16'h0000, 8'h00);
				push_byte(8'($urandom));
				push_byte(8'($urandom));
			end
		end else if (pick < 92) begin
			// frame that stalls partway through its header while the timer runs
			len = 16'($urandom_range(0, 8));
			n = $urandom_range(1, 5);
			for (int i = 0; i < n; i++)
				push_byte((i < 3) ? START_CODE[23 - 8 * i -: 8]
					: ((i == 3) ? len[15:8] : len[7:0]));
			n = $urandom_range(1, 60);
			repeat (n) begin
				stim_q.push_back({OP_TICK, 8'($urandom)});
				phase_items++;
			end
		end else begin
			n = $urandom_range(1, 3);
			repeat (n)
				push_byte(8'($urandom));
		end
	endfunction

	task automatic send_request(uart_req_t q);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= q.op;
		s_tdata <= q.rx_byte;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic send_queued();
		while (stim_q.size() != 0)
			send_request(stim_q.pop_front());
	endtask

	// let the pipeline empty before touching the registers
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic set_limits(logic [15:0] max_len, logic [15:0] tick_limit);
		cfg_we <= 1'b1;
		cfg_index <= REG_MAX_PAYLOAD;
		cfg_data <= max_len;
		@(posedge clk);
		sb.write_reg(REG_MAX_PAYLOAD, max_len);
		cfg_index <= REG_TIMEOUT_TICKS;
		cfg_data <= tick_limit;
		@(posedge clk);
		sb.write_reg(REG_TIMEOUT_TICKS, tick_limit);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ack, not-ack, bad start, too long, tick while hunting
		push_header(START_CODE, 16'h0000, LCS_ACK_BYTE);
		push_byte(ACK_POST_BYTE);
		push_header(START_CODE, 16'h0000, LCS_ACK_BYTE);
		push_byte(8'hff);
		push_header(24'hff00ff, 16'hffff, 8'h00);
		push_header(START_CODE, 16'h011b, len_checksum(16'h011b));
		stim_q.push_back({OP_TICK, 8'hff});
		send_queued();
		wait_quiet();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: ;
				1: set_limits(16'd0, 16'd1);
				2: set_limits(16'hffff, 16'hffff);
				3: set_limits(16'd5, 16'd6);
				4: set_limits(MAX_PAYLOAD_RESET, TIMEOUT_TICKS_RESET);
				default: set_limits(16'($urandom_range(1, 40)), 16'($urandom_range(2, 40)));
			endcase
			tx_idle_pct = (p < 2) ? 37 : ((p < 4) ? 50 : 0);
			rx_idle_pct = (p < 2) ? 50 : ((p < 4) ? 37 : 0);
			tick_pct = 6;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				build_burst();
				send_queued();
			end
			wait_quiet();
		end

		$display("covered %0d requests and %0d results over %0d limit settings",
			sb.requests, sb.results, NUM_PHASES + 1);
		$display("kinds: data %0d done %0d ack %0d badstart %0d badlcs %0d",
			sb.kind_hits[KIND_DATA], sb.kind_hits[KIND_DONE], sb.kind_hits[KIND_ACK],
			sb.kind_hits[KIND_BADSTART], sb.kind_hits[KIND_BADLCS]);
		$display("       long %0d tmo %0d nack %0d",
			sb.kind_hits[KIND_TOOLONG], sb.kind_hits[KIND_TIMEOUT],
			sb.kind_hits[KIND_NOTACK]);
		if (sb.expected.size() != 0)
			$display("error: %0d expected results never arrived", sb.expected.size());
		if (sb.mismatches == 0 && sb.expected.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#(2 * HALF_PERIOD * 400000);
		$display("error: run did not finish in time");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
